// ----- rtl/kasa_pkg.sv -----
// shared types and constants for the keyed atlas shelf allocator
package kasa_pkg;

    localparam int SLOTS_DEF     = 64;
    localparam int ATLAS_DIM_DEF = 2048;

    localparam int KEY_W    = 32;
    localparam int DIM_W    = 12;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int POS_W    = 2 * DIM_W;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_HIT       = 3'd0,
        ST_PLACED    = 3'd1,
        ST_NO_SLOT   = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_FULL      = 3'd4,
        ST_FORGOTTEN = 3'd5,
        ST_ABSENT    = 3'd6
    } status_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    scan;
        logic    pos_rd;
        logic    wrap;
        logic    fit;
        logic    emit;
        status_t code;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic scan_done;
        logic forget;
        logic found;
        logic free_found;
        logic too_large;
        logic fits;
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/kasa_ctrl.sv -----
// controller state machine: sequences scan, hit readback and shelf placement
module kasa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  kasa_pkg::sts_t sts,
    output kasa_pkg::cmd_t cmd
);
    import kasa_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        SCAN,
        DECIDE,
        POS,
        HIT_OUT,
        WRAP,
        FIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_HIT;
        s_ready    = 1'b0;
        case (state_reg)
            IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = SCAN;
                end
            end
            SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = DECIDE;
                end
            end
            DECIDE: begin
                if (sts.forget) begin
                    if (sts.out_free) begin
                        cmd.emit   = 1'b1;
                        cmd.code   = sts.found ? ST_FORGOTTEN : ST_ABSENT;
                        state_next = IDLE;
                    end
                end else if (sts.found) begin
                    state_next = POS;
                end else if (!sts.free_found || sts.too_large) begin
                    if (sts.out_free) begin
                        cmd.emit   = 1'b1;
                        cmd.code   = !sts.free_found ? ST_NO_SLOT : ST_TOO_LARGE;
                        state_next = IDLE;
                    end
                end else begin
                    state_next = WRAP;
                end
            end
            POS: begin
                cmd.pos_rd = 1'b1;
                state_next = HIT_OUT;
            end
            HIT_OUT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.code   = ST_HIT;
                    state_next = IDLE;
                end
            end
            WRAP: begin
                cmd.wrap   = 1'b1;
                state_next = FIT;
            end
            FIT: begin
                if (sts.out_free) begin
                    cmd.fit    = 1'b1;
                    cmd.emit   = 1'b1;
                    cmd.code   = sts.fits ? ST_PLACED : ST_FULL;
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/kasa_dp.sv -----
// datapath: slot table, key scan pipeline, shelf cursor and result register
module kasa_dp #(
    parameter int SLOTS     = kasa_pkg::SLOTS_DEF,
    parameter int ATLAS_DIM = kasa_pkg::ATLAS_DIM_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_kind,
    input  logic [kasa_pkg::KEY_W-1:0]    s_image_key,
    input  logic [kasa_pkg::DIM_W-1:0]    s_rect_width,
    input  logic [kasa_pkg::DIM_W-1:0]    s_rect_height,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [kasa_pkg::STATUS_W-1:0] m_status,
    output logic [kasa_pkg::SLOT_W-1:0]   m_slot_index,
    output logic [kasa_pkg::DIM_W-1:0]    m_place_x,
    output logic [kasa_pkg::DIM_W-1:0]    m_place_y,
    input  kasa_pkg::cmd_t                cmd,
    output kasa_pkg::sts_t                sts
);
    import kasa_pkg::*;

    localparam int IW  = $clog2(SLOTS);
    localparam int CTW = $clog2(SLOTS + 1);
    localparam int CW  = $clog2(2 * ATLAS_DIM + 1);
    localparam int SW  = ((CW > DIM_W) ? CW : DIM_W) + 1;

    // slot table
    logic [SLOTS-1:0] used_reg;
    logic [KEY_W-1:0] key_mem [SLOTS];
    logic [POS_W-1:0] pos_mem [SLOTS];

    // request registers
    logic             req_kind_reg;
    logic [KEY_W-1:0] req_key_reg;
    logic [DIM_W-1:0] req_w_reg;
    logic [DIM_W-1:0] req_h_reg;

    // scan pipeline
    logic [CTW-1:0]   idx_reg;
    logic             rd_valid_reg;
    logic [IW-1:0]    rd_idx_reg;
    logic             rd_used_reg;
    logic [KEY_W-1:0] rd_key_reg;
    logic             found_reg;
    logic [IW-1:0]    found_idx_reg;
    logic             free_reg;
    logic [IW-1:0]    free_idx_reg;
    logic [POS_W-1:0] pos_rd_reg;

    // shelf cursor
    logic [CW-1:0] cursor_x_reg;
    logic [CW-1:0] cursor_y_reg;
    logic [CW-1:0] shelf_reg;

    // result register
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [SLOT_W-1:0]   m_slot_reg;
    logic [DIM_W-1:0]    m_x_reg;
    logic [DIM_W-1:0]    m_y_reg;

    logic          issue;
    logic [IW-1:0] idx_addr;
    logic          match;
    logic          wrap_need;
    logic          fits;
    logic          too_large;

    assign idx_addr  = idx_reg[IW-1:0];
    assign issue     = (idx_reg < CTW'(SLOTS));
    assign match     = rd_valid_reg && rd_used_reg && (rd_key_reg == req_key_reg);
    assign too_large = (SW'(req_w_reg) > SW'(ATLAS_DIM)) || (SW'(req_h_reg) > SW'(ATLAS_DIM));
    assign wrap_need = (SW'(cursor_x_reg) + SW'(req_w_reg)) > SW'(ATLAS_DIM);
    assign fits      = (SW'(cursor_y_reg) + SW'(req_h_reg)) <= SW'(ATLAS_DIM);

    // status to controller
    always_comb begin
        sts.scan_done  = !issue && !rd_valid_reg;
        sts.forget     = req_kind_reg;
        sts.found      = found_reg;
        sts.free_found = free_reg;
        sts.too_large  = too_large;
        sts.fits       = fits;
        sts.out_free   = !m_valid_reg || m_ready;
    end

    // request capture and payload of the scan stage
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_kind_reg <= s_kind;
            req_key_reg  <= s_image_key;
            req_w_reg    <= s_rect_width;
            req_h_reg    <= s_rect_height;
        end
        if (cmd.scan && issue) begin
            rd_idx_reg  <= idx_addr;
            rd_used_reg <= used_reg[idx_addr];
        end
    end

    // key memory
    always_ff @(posedge aclk) begin
        if (cmd.fit && fits) begin
            key_mem[free_idx_reg] <= req_key_reg;
        end
        if (cmd.scan && issue) begin
            rd_key_reg <= key_mem[idx_addr];
        end
    end

    // position memory
    always_ff @(posedge aclk) begin
        if (cmd.fit && fits) begin
            pos_mem[free_idx_reg] <= {DIM_W'(cursor_y_reg), DIM_W'(cursor_x_reg)};
        end
        if (cmd.pos_rd) begin
            pos_rd_reg <= pos_mem[found_idx_reg];
        end
    end

    // scan control, used bits and cursor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            idx_reg       <= CTW'(SLOTS);
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            shelf_reg     <= '0;
        end else begin
            if (cmd.load) begin
                idx_reg      <= '0;
                rd_valid_reg <= 1'b0;
                found_reg    <= 1'b0;
                free_reg     <= 1'b0;
            end
            if (cmd.scan) begin
                rd_valid_reg <= issue;
                if (issue) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                // first key match; a forget frees every match
                if (match) begin
                    if (req_kind_reg) begin
                        used_reg[rd_idx_reg] <= 1'b0;
                    end
                    if (!found_reg) begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= rd_idx_reg;
                    end
                end
                // lowest free slot
                if (rd_valid_reg && !rd_used_reg && !free_reg) begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
            end
            // start a new row when the rectangle does not fit this one
            if (cmd.wrap && wrap_need) begin
                cursor_x_reg <= '0;
                cursor_y_reg <= cursor_y_reg + shelf_reg;
                shelf_reg    <= '0;
            end
            // claim the slot and advance the cursor
            if (cmd.fit && fits) begin
                used_reg[free_idx_reg] <= 1'b1;
                cursor_x_reg <= CW'(SW'(cursor_x_reg) + SW'(req_w_reg));
                if (SW'(req_h_reg) > SW'(shelf_reg)) begin
                    shelf_reg <= CW'(req_h_reg);
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_status_reg <= cmd.code;
            case (cmd.code)
                ST_HIT: begin
                    m_slot_reg <= SLOT_W'(found_idx_reg);
                    m_x_reg    <= pos_rd_reg[DIM_W-1:0];
                    m_y_reg    <= pos_rd_reg[POS_W-1:DIM_W];
                end
                ST_PLACED: begin
                    m_slot_reg <= SLOT_W'(free_idx_reg);
                    m_x_reg    <= DIM_W'(cursor_x_reg);
                    m_y_reg    <= DIM_W'(cursor_y_reg);
                end
                ST_FORGOTTEN: begin
                    m_slot_reg <= SLOT_W'(found_idx_reg);
                    m_x_reg    <= '0;
                    m_y_reg    <= '0;
                end
                default: begin
                    m_slot_reg <= '0;
                    m_x_reg    <= '0;
                    m_y_reg    <= '0;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_slot_index = m_slot_reg;
    assign m_place_x    = m_x_reg;
    assign m_place_y    = m_y_reg;

endmodule

// ----- rtl/keyed_atlas_shelf_allocator.sv -----
// top level of the keyed atlas shelf allocator
//
// Keeps SLOTS image slots, each a key and a position in an ATLAS_DIM square
// atlas, plus a shelf cursor. A request on the s_ channel is either a lookup
// (s_kind 0) or a forget (s_kind 1); each request gives exactly one result
// on the m_ channel. Both channels are valid/ready.
// A lookup returns the stored position on a key hit; on a miss it claims the
// lowest free slot and places the rectangle on the current shelf, opening a
// new shelf when the row is full. A forget frees every slot with the key.
// Timing: every request walks the whole key memory through its single read
// port, one slot per cycle, and a new request can be taken once its result
// is loaded into the output register.
// One request is in work at a time; s_ready is high while the block is idle.
// The result sits in an output register; a stalled receiver holds it there,
// a next request may still be taken, and its result waits until m_ready.
// Reset (aresetn low, synchronous) frees all slots, clears the cursor and
// drops m_valid; the key and position memories need no clearing.
module keyed_atlas_shelf_allocator #(
    parameter int SLOTS     = kasa_pkg::SLOTS_DEF,
    parameter int ATLAS_DIM = kasa_pkg::ATLAS_DIM_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [kasa_pkg::KEY_W-1:0]    s_image_key,
    input  logic [kasa_pkg::DIM_W-1:0]    s_rect_width,
    input  logic [kasa_pkg::DIM_W-1:0]    s_rect_height,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [kasa_pkg::STATUS_W-1:0] m_status,
    output logic [kasa_pkg::SLOT_W-1:0]   m_slot_index,
    output logic [kasa_pkg::DIM_W-1:0]    m_place_x,
    output logic [kasa_pkg::DIM_W-1:0]    m_place_y
);
    import kasa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // controller
    kasa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath
    kasa_dp #(
        .SLOTS     (SLOTS),
        .ATLAS_DIM (ATLAS_DIM)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_kind        (s_kind),
        .s_image_key   (s_image_key),
        .s_rect_width  (s_rect_width),
        .s_rect_height (s_rect_height),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_slot_index  (m_slot_index),
        .m_place_x     (m_place_x),
        .m_place_y     (m_place_y),
        .cmd           (cmd),
        .sts           (sts)
    );

    // one request in work at a time
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while another is in work");

    // results without a slot carry no slot and no position
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_NO_SLOT || m_status == ST_TOO_LARGE ||
                     m_status == ST_FULL || m_status == ST_ABSENT))
        |-> (m_slot_index == '0 && m_place_x == '0 && m_place_y == '0))
        else $error("slot or position set on a result without a slot");

    // a forget result carries no position
    a_forget_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FORGOTTEN) |-> (m_place_x == '0 && m_place_y == '0))
        else $error("position set on a forget result");

    // reset drops the result
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule
